@@ hw/rtl/cssms_pkg.sv @@
// ----------------------------------------------------------------------------
// cssms_pkg
// Shared types and constants of the current-sensed stall motor sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cssms_pkg;

  // averaging window depth
  localparam int WindowSamples = 10;
  localparam int SlotW         = (WindowSamples > 1) ? $clog2(WindowSamples) : 1;
  localparam int SumW          = 16 + $clog2(WindowSamples + 1);
  localparam int BoundW        = 15 + $clog2(WindowSamples + 1);

  // configuration register indexes
  localparam logic [1:0] RegCurrentLimit = 2'd0;
  localparam logic [1:0] RegDriveDuty    = 2'd1;
  localparam logic [1:0] RegStartDelay   = 2'd2;
  localparam logic [1:0] RegGapClear     = 2'd3;

  localparam logic [14:0] CurrentLimitRst = 15'd500;
  localparam logic [11:0] DriveDutyRst    = 12'd2048;
  localparam logic [15:0] StartDelayRst   = 16'd500;
  localparam logic [15:0] GapClearRst     = 16'd500;

  // operation codes
  localparam logic OpMove = 1'b0;
  localparam logic OpTick = 1'b1;

  // position codes
  localparam logic [1:0] PosOpen    = 2'd0;
  localparam logic [1:0] PosClosed  = 2'd1;
  localparam logic [1:0] PosUnknown = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [1:0]        move_kind;
    logic signed [15:0] current_ma;
    logic              sample_valid;
  } in_word_t;

  typedef struct packed {
    logic [11:0] in1_duty;
    logic [11:0] in2_duty;
    logic [1:0]  position;
    logic        busy_res;
    logic        over_limit;
    logic        move_done;
  } out_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/current_sensed_stall_motor_sequencer.sv @@
// ----------------------------------------------------------------------------
// current_sensed_stall_motor_sequencer
// H-bridge move sequencer that stops a move on windowed motor current.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid_i/in_ready_o/in_data_i  | word in
//  out      | out_valid_o/out_ready_i/out_data_o | word out
//  cfg      | cfg_we_i/cfg_idx_i/cfg_wdata_i   | write only
//
//  One word per cycle unless the output stalls; each result shows next cycle.
//  The sample ring sits in a RAM with a registered read; the entry at the
//  current slot is always prefetched, with write-to-read forwarding.
//  Reset clears control state and the ring valid bits at once, no sweep.
//  A stalled output word only blocks input when out_ready_i is low.
// ----------------------------------------------------------------------------
`default_nettype none

module current_sensed_stall_motor_sequencer (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  cssms_pkg::in_word_t    in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output cssms_pkg::out_word_t   out_data_o,
  input  wire                    cfg_we_i,
  input  wire  [1:0]             cfg_idx_i,
  input  wire  [15:0]            cfg_wdata_i
);

  localparam int W = cssms_pkg::WindowSamples;
  localparam int SW = cssms_pkg::SlotW;
  localparam int SUMW = cssms_pkg::SumW;
  localparam int BW = cssms_pkg::BoundW;
  localparam logic [SW-1:0] LastSlot = SW'(W - 1);

  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhDelay   = 2'd1;
  localparam logic [1:0] PhMonitor = 2'd2;

  // configuration
  logic [14:0] limit_q;
  logic [11:0] duty_q;
  logic [15:0] start_dly_q;
  logic [15:0] gap_clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= cssms_pkg::CurrentLimitRst;
      duty_q      <= cssms_pkg::DriveDutyRst;
      start_dly_q <= cssms_pkg::StartDelayRst;
      gap_clr_q   <= cssms_pkg::GapClearRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cssms_pkg::RegCurrentLimit: limit_q     <= cfg_wdata_i[14:0];
        cssms_pkg::RegDriveDuty:    duty_q      <= cfg_wdata_i[11:0];
        cssms_pkg::RegStartDelay:   start_dly_q <= cfg_wdata_i;
        cssms_pkg::RegGapClear:     gap_clr_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [1:0]            pos_q, pos_d;
  logic [1:0]            phase_q, phase_d;
  logic [1:0]            move_q, move_d;
  logic [15:0]           dly_q, dly_d;
  logic [15:0]           gap_q, gap_d;
  logic [SW-1:0]         slot_q, slot_d;
  logic signed [SUMW-1:0] sum_q, sum_d;
  logic [W-1:0]          vld_q, vld_d;

  // ring RAM
  logic signed [15:0]    ring_mem [W];
  logic signed [15:0]    rd_q;

  logic                  accept;
  logic                  clear;
  logic                  wr_en;
  logic [SW-1:0]         wr_slot;
  logic                  monitor;
  logic [15:0]           gap_inc;
  logic signed [15:0]    old_val;
  logic signed [BW:0]    bound;
  logic                  over;
  logic                  done;
  logic                  out_valid_q;
  cssms_pkg::out_word_t  out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign bound = (BW + 1)'(W) * $signed({1'b0, (BW)'(limit_q)});

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    move_d  = move_q;
    dly_d   = dly_q;
    gap_d   = gap_q;
    slot_d  = slot_q;
    sum_d   = sum_q;
    vld_d   = vld_q;
    clear   = 1'b0;
    wr_en   = 1'b0;
    wr_slot = slot_q;
    monitor = 1'b0;
    done    = 1'b0;
    gap_inc = gap_q;
    old_val = '0;

    if (accept) begin
      if (in_data_i.operation == cssms_pkg::OpMove) begin
        if (phase_q == PhIdle && pos_q != {1'b0, in_data_i.move_kind[0]}) begin
          move_d  = in_data_i.move_kind;
          phase_d = PhDelay;
          dly_d   = '0;
        end
      end else if (phase_q != PhIdle) begin
        if (phase_q == PhDelay) begin
          if (dly_q < start_dly_q) begin
            dly_d = dly_q + 16'd1;
          end else begin
            clear   = 1'b1;
            gap_inc = '0;
            phase_d = PhMonitor;
            monitor = 1'b1;
          end
        end else begin
          monitor = 1'b1;
        end

        if (monitor) begin
          if (gap_inc != 16'hFFFF) begin
            gap_inc = gap_inc + 16'd1;
          end
          gap_d = gap_inc;
          if (in_data_i.sample_valid) begin
            if (gap_inc > gap_clr_q) begin
              clear = 1'b1;
            end
            gap_d = '0;
          end
        end
      end
    end

    if (clear) begin
      vld_d  = '0;
      slot_d = '0;
      sum_d  = '0;
    end

    if (accept && monitor && in_data_i.sample_valid) begin
      wr_en   = 1'b1;
      wr_slot = clear ? '0 : slot_q;
      // prefetched entry is for slot_q; a cleared window reads as zero
      old_val = (!clear && vld_q[slot_q]) ? rd_q : 16'sd0;
      sum_d   = sum_d - SUMW'(old_val) + SUMW'(in_data_i.current_ma);
      vld_d[wr_slot] = 1'b1;
      slot_d  = (wr_slot == LastSlot) ? '0 : wr_slot + SW'(1);
    end

    over = $signed((BW + 1)'(sum_d)) > bound;
    if (SUMW > BW + 1) begin
      over = sum_d > SUMW'(bound);
    end

    if (wr_en) begin
      if ((move_q[1] == 1'b0) ? over : !over) begin
        pos_d   = {1'b0, move_q[0]};
        phase_d = PhIdle;
        done    = 1'b1;
      end
    end

    out_d.in1_duty   = (phase_d != PhIdle && !move_d[0]) ? duty_q : '0;
    out_d.in2_duty   = (phase_d != PhIdle &&  move_d[0]) ? duty_q : '0;
    out_d.position   = pos_d;
    out_d.busy_res   = (phase_d != PhIdle);
    out_d.over_limit = over;
    out_d.move_done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= cssms_pkg::PosUnknown;
      phase_q     <= PhIdle;
      move_q      <= '0;
      dly_q       <= '0;
      gap_q       <= '0;
      slot_q      <= '0;
      sum_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      move_q  <= move_d;
      dly_q   <= dly_d;
      gap_q   <= gap_d;
      slot_q  <= slot_d;
      sum_q   <= sum_d;
      vld_q   <= vld_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  // ring RAM: write the new sample, prefetch the entry at the next slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_slot] <= in_data_i.current_ma;
    end
    if (wr_en && wr_slot == slot_d) begin
      rd_q <= in_data_i.current_ma;
    end else begin
      rd_q <= ring_mem[slot_d];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/cssms_checker.sv @@
// ----------------------------------------------------------------------------
// cssms_checker
// Port-level checks on the result words of the motor sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cssms_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input cssms_pkg::out_word_t out_data_o
);

  // a finished move leaves the bridge idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.move_done |-> !out_data_o.busy_res)
    else $error("move_done with busy set");

  // a finished move always lands on a known position
  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.move_done |->
      (out_data_o.position == cssms_pkg::PosOpen ||
       out_data_o.position == cssms_pkg::PosClosed))
    else $error("move_done without a known position");

  // bridge off when not moving
  a_idle_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |->
      out_data_o.in1_duty == '0 && out_data_o.in2_duty == '0)
    else $error("duty driven while idle");

  // never drive both bridge inputs
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.in1_duty == '0 || out_data_o.in2_duty == '0)
    else $error("both bridge inputs driven");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

endmodule

bind current_sensed_stall_motor_sequencer cssms_checker u_cssms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
